// ----- hw/rtl/ftsu_pkg.sv -----
// ----------------------------------------------------------------------------
// ftsu_pkg
// Shared types and constants for the PWM frequency and duty timer setup unit.
// ----------------------------------------------------------------------------
package ftsu_pkg;

    // default configuration
    localparam int unsigned CLOCK_HZ_DEF     = 16000000;
    localparam int unsigned NUM_CHANNELS_DEF = 3;

    // field widths
    localparam int FREQ_W   = 24;
    localparam int DUTY_W   = 14;
    localparam int TOP_W    = 16;
    localparam int CODE_W   = 3;
    localparam int CH_W     = 2;
    localparam int STATUS_W = 2;

    // duty * (top + 1) + half scale stays below 2^30
    localparam int PROD_W = 30;

    // x / 10000 as ((x >> 4) * RECIP_M) >> RECIP_SH, exact for x below 2^PROD_W
    localparam int                 DUTY_PRE_SH = 4;
    localparam int                 RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP_M     = 27'd109951163;
    localparam int                 RECIP_SH    = 36;

    // stream widths
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 4;

    localparam int unsigned FREQ_RESET = 20000;
    localparam int unsigned DUTY_FULL  = 10000;
    localparam int unsigned DUTY_HALF  = DUTY_FULL / 2;
    localparam int unsigned MAX_PERIOD = 65536;

    // prescalers 1, 8, 64, 256, 1024 as right shifts of clock / freq
    localparam int NUM_PRESC = 5;
    localparam int PRESC_SHIFT [NUM_PRESC] = '{0, 3, 6, 8, 10};

    // result status codes
    localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STOP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // opcodes
    localparam logic OP_FREQ = 1'b0;
    localparam logic OP_DUTY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_freq;
        logic scale;
        logic pick;
        logic mul;
        logic cap;
        logic set_stop;
        logic emit;
    } t_ftsu_cmd;

    // datapath to controller
    typedef struct packed {
        logic ch_ok;
        logic stopped;
        logic div_done;
        logic fit;
        logic out_free;
    } t_ftsu_stat;

endpackage

// ----- hw/rtl/ftsu_div.sv -----
// ----------------------------------------------------------------------------
// ftsu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftsu_div import ftsu_pkg::*; #(
    parameter int DW = 30,
    parameter int VW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_div;
    logic [DW-1:0]    r_quo;
    logic [VW:0]      trial;
    logic [VW:0]      diff;

    // trial subtract of the shifted partial remainder
    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!diff[VW]) begin
                r_rem <= diff[VW-1:0];
            end else begin
                r_rem <= trial[VW-1:0];
            end
            r_quo <= {r_quo[DW-2:0], ~diff[VW]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/ftsu_dp.sv -----
// ----------------------------------------------------------------------------
// ftsu_dp
// Datapath: per-channel stores, prescaler pick, duty scaling, result register.
// ----------------------------------------------------------------------------
module ftsu_dp import ftsu_pkg::*; #(
    parameter int unsigned CLOCK_HZ     = CLOCK_HZ_DEF,
    parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ftsu_cmd           i_cmd,
    output t_ftsu_stat          o_stat,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic [S_USER_W-1:0] i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic [M_USER_W-1:0] o_m_tuser
);

    localparam int CLK_W = $clog2(CLOCK_HZ + 1);
    localparam int DW    = CLK_W;
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [FREQ_W-1:0]   r_freq [NUM_CHANNELS];
    logic [DUTY_W-1:0]   r_duty [NUM_CHANNELS];

    logic [FREQ_W-1:0]   in_value;
    logic                in_op;
    logic [CH_W-1:0]     in_ch;
    logic [IDX_W-1:0]    in_idx;
    logic [DUTY_W-1:0]   duty_sat;

    logic [CH_W-1:0]     r_ch;
    logic [FREQ_W-1:0]   r_f;
    logic [DUTY_W-1:0]   r_d;
    logic [STATUS_W-1:0] r_status;
    logic [TOP_W-1:0]    r_top;
    logic [TOP_W-1:0]    r_cmp;
    logic [CODE_W-1:0]   r_code;
    logic [PROD_W-1:0]   r_prod;
    logic [TOP_W:0]      r_scale;

    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [FREQ_W-1:0]   div_divisor;
    logic                div_done;
    logic [DW-1:0]       quo;

    logic                fit;
    logic [TOP_W-1:0]    pick_top;
    logic [CODE_W-1:0]   pick_code;
    logic [DUTY_W+TOP_W:0] prod_full;
    logic [PROD_W-DUTY_PRE_SH+RECIP_W-1:0] recip_prod;

    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic [M_USER_W-1:0] r_m_user;

    // input fields
    assign in_value = i_s_tdata[FREQ_W-1:0];
    assign in_op    = i_s_tuser[0];
    assign in_ch    = i_s_tuser[CH_W:1];
    assign in_idx   = IDX_W'(in_ch);
    assign duty_sat = (in_value > FREQ_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL)
                                                      : in_value[DUTY_W-1:0];

    // per-channel stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_freq[i] <= FREQ_W'(FREQ_RESET);
                r_duty[i] <= '0;
            end
        end else if (i_cmd.capture && o_stat.ch_ok) begin
            if (in_op == OP_FREQ) begin
                r_freq[in_idx] <= in_value;
            end else begin
                r_duty[in_idx] <= duty_sat;
            end
        end
    end

    // working copy of the addressed channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch <= in_ch;
            r_f  <= (in_op == OP_FREQ) ? in_value : r_freq[in_idx];
            r_d  <= (in_op == OP_DUTY) ? duty_sat : r_duty[in_idx];
        end
    end

    // divider: clock / freq
    assign div_start    = i_cmd.div_freq;
    assign div_dividend = DW'(CLOCK_HZ);
    assign div_divisor  = r_f;

    ftsu_div #(
        .DW (DW),
        .VW (FREQ_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // first prescaler whose period lands in 2..65536 counts
    always_comb begin
        logic [DW-1:0] q;
        fit       = 1'b0;
        pick_top  = '0;
        pick_code = '0;
        q         = '0;
        for (int k = NUM_PRESC - 1; k >= 0; k--) begin
            q = quo >> PRESC_SHIFT[k];
            if (q >= DW'(2) && q <= DW'(MAX_PERIOD)) begin
                fit       = 1'b1;
                pick_top  = TOP_W'(q - DW'(1));
                pick_code = CODE_W'(k + 1);
            end
        end
    end

    // duty * (top + 1); half scale is added for rounding when r_prod is loaded
    assign prod_full = r_d * ({1'b0, r_top} + (TOP_W + 1)'(1));

    // divide by full scale through a reciprocal multiply
    assign recip_prod = r_prod[PROD_W-1:DUTY_PRE_SH] * RECIP_M;

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_stop) begin
            r_status <= ST_STOP;
            r_top    <= '0;
            r_cmp    <= '0;
            r_code   <= '0;
        end else if (i_cmd.pick) begin
            r_status <= fit ? ST_RUN : ST_RANGE;
            r_top    <= pick_top;
            r_code   <= pick_code;
            r_cmp    <= '0;
        end else if (i_cmd.mul) begin
            r_prod <= PROD_W'(prod_full + (DUTY_W + TOP_W + 1)'(DUTY_HALF));
        end else if (i_cmd.scale) begin
            r_scale <= recip_prod[RECIP_SH+TOP_W:RECIP_SH];
        end else if (i_cmd.cap) begin
            r_cmp <= (r_scale > {1'b0, r_top}) ? r_top : r_scale[TOP_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_data <= {(M_DATA_W - CODE_W - 2 * TOP_W)'(0), r_code, r_cmp, r_top};
            r_m_user <= {r_status, r_ch};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // status toward the controller
    assign o_stat.ch_ok    = 32'(in_ch) < NUM_CHANNELS;
    assign o_stat.stopped  = (r_f == '0) || (r_d == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.fit      = fit;
    assign o_stat.out_free = !r_m_valid || i_m_tready;

endmodule

// ----- hw/rtl/ftsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// ftsu_ctrl
// Command sequencer: capture, stop check, frequency divide, prescaler pick, duty scaling, output.
// ----------------------------------------------------------------------------
module ftsu_ctrl import ftsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_ftsu_stat i_stat,
    output t_ftsu_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_PICK  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_CAP   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept && i_stat.ch_ok) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.stopped) begin
                    o_cmd.set_stop = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.div_freq = 1'b1;
                    n_state        = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_stat.div_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = i_stat.fit ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/pwm_frequency_duty_timer_setup_unit.sv -----
// ----------------------------------------------------------------------------
// pwm_frequency_duty_timer_setup_unit
// A running command passes CHECK, DIV1, PICK, MUL, SCALE, CAP and OUT; the
//   clock / freq divider in DIV1 makes one quotient bit per cycle over DW bits
//   (DW = bit width of CLOCK_HZ, 24 at the default clock).
// Stopped commands go from CHECK to OUT; out-of-range commands go from PICK to
//   OUT; a command for a missing channel is dropped in IDLE with no output.
// One command at a time; a finished item waits in the output register.
// Reset (i_rst_n low, synchronous): 20000 Hz and zero duty in every channel.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_timer_setup_unit import ftsu_pkg::*; #(
    parameter int unsigned CLOCK_HZ     = CLOCK_HZ_DEF,
    parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // value[23:0]
    input  logic [S_USER_W-1:0] s_tuser,   // opcode[0], channel[2:1]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // top[15:0], compare[31:16], prescale[34:32]
    output logic [M_USER_W-1:0] m_tuser    // channel_out[1:0], status[3:2]
);

    t_ftsu_cmd  cmd;
    t_ftsu_stat stat;

    // sequencer
    ftsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    ftsu_dp #(
        .CLOCK_HZ     (CLOCK_HZ),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule
